>>> rtl/wmsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmsd_pkg
// Types and fixed constants shared by the windowed mean / std-dev block.
// ----------------------------------------------------------------------------
package wmsd_pkg;

    localparam int SUM_BITS    = 31;               // running sum, two's complement
    localparam int SQ_BITS     = 54;               // running sum of squares
    localparam int MEAN_W      = 32;
    localparam int STD_W       = 32;
    localparam int COUNT_W     = 7;
    localparam int CFG_W       = 7;
    localparam int NUM_W       = SUM_BITS + 8;     // |sum| * 256
    localparam int D_W         = 64;               // variance numerator
    localparam int FRAC_SHIFT  = 16;
    localparam int DQ_W        = D_W + FRAC_SHIFT; // divider dividend
    localparam int SQRT_STEPS  = D_W / 2;
    localparam int STEP_W      = 7;
    localparam int OUT_TDATA_W = 72;
    localparam int APB_AW      = 3;

    localparam logic [CFG_W-1:0] WL_RESET = 7'd64;

    localparam logic       REG_WINDOW_LENGTH = 1'b0;  // word index on paddr[2]
    localparam logic       CMD_ADD           = 1'b0;
    localparam logic       CMD_CLEAR         = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_PREP,
        S_MUL,
        S_DIVM,
        S_CHK,
        S_DIVV,
        S_SQLD,
        S_SQRT,
        S_STD,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic clear;
        logic rd;
        logic square;
        logic update;
        logic prep;
        logic mul_step;
        logic div_step;
        logic mean_cap;
        logic divv_ld;
        logic std_zero;
        logic sqrt_ld;
        logic sqrt_step;
        logic std_cap;
        logic out_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic var_ok;
    } t_dp_sts;

endpackage
`default_nettype wire

>>> rtl/windowed_mean_and_std_dev_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_mean_and_std_dev_top
// Sliding-window mean and sample standard deviation, Q8 outputs.
// ----------------------------------------------------------------------------
// Every input word (add or clear) gives one result word. An add passes
// through the serial multiply of the count, the bit-a-cycle restoring divider
// (once for the mean, once for the variance) and the bit-pair square root;
// when fewer than two samples are held, or n * sum of squares is below the
// squared sum, the variance and root are skipped and the deviation is zero.
// A clear skips the arithmetic. One word is accepted at a time; a finished
// result waits in the output register while the next word is accepted.
// window_length is 1..MAX_WINDOW (0 acts as 1); follow a change by a clear.
module windowed_mean_and_std_dev_top #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // sample
    input  wire logic                                s_tuser,  // command
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [wmsd_pkg::OUT_TDATA_W-1:0]         m_tdata,  // mean_q8, std_dev_q8, filled_count
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [wmsd_pkg::APB_AW-1:0]         paddr,
    input  wire logic [31:0]                         pwdata,
    output logic      [31:0]                         prdata,
    output logic                                     pready
);
    import wmsd_pkg::*;

    logic [CFG_W-1:0]   r_window_length;
    t_dp_cmd            cmd;
    t_dp_sts            sts;
    logic [MEAN_W-1:0]  mean;
    logic [STD_W-1:0]   std_dev;
    logic [COUNT_W-1:0] count;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ? 32'(r_window_length) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WL_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_WINDOW_LENGTH)) begin
            r_window_length <= pwdata[CFG_W-1:0];
        end
    end

    wmsd_ctrl #(.MAX_WINDOW(MAX_WINDOW)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_tvalid),
        .i_command (s_tuser),
        .o_s_ready (s_tready),
        .o_m_valid (m_tvalid),
        .i_m_ready (m_tready),
        .o_cmd     (cmd),
        .i_sts     (sts)
    );

    wmsd_dp #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_window_length (r_window_length),
        .i_sample        (s_tdata[SAMPLE_BITS-1:0]),
        .o_mean          (mean),
        .o_std           (std_dev),
        .o_count         (count)
    );

    assign m_tdata = {1'b0, count, std_dev, mean};

`ifndef ASSERT_OFF
    // one word at a time: ready drops after an accept
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // an empty window reports zero statistics
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (MAX_WINDOW < 128) && m_tvalid && (m_tdata[70:64] == '0)
        |-> (m_tdata[63:0] == '0))
        else $error("nonzero statistics with empty window");

    // a deviation needs at least two samples
    a_std_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (MAX_WINDOW < 128) && m_tvalid && (m_tdata[63:32] != '0)
        |-> (m_tdata[70:64] >= 7'd2))
        else $error("deviation reported with fewer than two samples");
`endif

endmodule
`default_nettype wire

>>> rtl/wmsd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmsd_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module wmsd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/wmsd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmsd_ctrl
// Sequencer: steps the datapath through update, multiply, divide and root.
// ----------------------------------------------------------------------------
module wmsd_ctrl #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_valid,
    input  wire logic              i_command,
    output logic                   o_s_ready,
    output logic                   o_m_valid,
    input  wire logic              i_m_ready,
    output wmsd_pkg::t_dp_cmd      o_cmd,
    input  wire wmsd_pkg::t_dp_sts i_sts
);
    import wmsd_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_valid, n_out_valid;
    logic                accept, last, out_free;

    assign accept   = i_s_valid && (r_state == S_IDLE);
    assign last     = (r_step == '0);
    assign out_free = !r_out_valid || i_m_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept) begin
                          n_state = (i_command == CMD_CLEAR) ? S_FINISH : S_READ;
                      end
            S_READ:   n_state = S_UPDATE;
            S_UPDATE: n_state = S_PREP;
            S_PREP:   n_state = S_MUL;
            S_MUL:    if (last) n_state = S_DIVM;
            S_DIVM:   if (last) n_state = S_CHK;
            S_CHK:    n_state = i_sts.var_ok ? S_DIVV : S_FINISH;
            S_DIVV:   if (last) n_state = S_SQLD;
            S_SQLD:   n_state = S_SQRT;
            S_SQRT:   if (last) n_state = S_STD;
            S_STD:    n_state = S_FINISH;
            S_FINISH: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_step = r_step - STEP_W'(1);
        unique case (r_state)
            S_PREP:  n_step = STEP_W'(CNT_W - 1);
            S_MUL:   if (last) n_step = STEP_W'(NUM_W - 1);
            S_CHK:   n_step = STEP_W'(DQ_W - 1);
            S_SQLD:  n_step = STEP_W'(SQRT_STEPS - 1);
            default: n_step = last ? r_step : r_step - STEP_W'(1);
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_s_ready       = (r_state == S_IDLE);
        o_cmd.clear     = accept && (i_command == CMD_CLEAR);
        o_cmd.rd        = accept && (i_command == CMD_ADD);
        o_cmd.square    = (r_state == S_READ);
        o_cmd.update    = (r_state == S_UPDATE);
        o_cmd.prep      = (r_state == S_PREP);
        o_cmd.mul_step  = (r_state == S_MUL);
        o_cmd.div_step  = (r_state == S_DIVM) || (r_state == S_DIVV);
        o_cmd.mean_cap  = (r_state == S_CHK);
        o_cmd.divv_ld   = (r_state == S_CHK) && i_sts.var_ok;
        o_cmd.std_zero  = (r_state == S_CHK) && !i_sts.var_ok;
        o_cmd.sqrt_ld   = (r_state == S_SQLD);
        o_cmd.sqrt_step = (r_state == S_SQRT);
        o_cmd.std_cap   = (r_state == S_STD);
        o_cmd.out_ld    = (r_state == S_FINISH) && out_free;
    end

    // hold the result word until taken
    always_comb begin
        n_out_valid = r_out_valid && !i_m_ready;
        if (o_cmd.out_ld) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_m_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end
endmodule
`default_nettype wire

>>> rtl/wmsd_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmsd_dp
// Datapath: sample ring, running sums, serial multiplier, shared restoring
// divider and bitwise integer square root.
// ----------------------------------------------------------------------------
module wmsd_dp #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire wmsd_pkg::t_dp_cmd             i_cmd,
    output wmsd_pkg::t_dp_sts                  o_sts,
    input  wire logic [wmsd_pkg::CFG_W-1:0]    i_window_length,
    input  wire logic [SAMPLE_BITS-1:0]        i_sample,
    output logic      [wmsd_pkg::MEAN_W-1:0]   o_mean,
    output logic      [wmsd_pkg::STD_W-1:0]    o_std,
    output logic      [wmsd_pkg::COUNT_W-1:0]  o_count
);
    import wmsd_pkg::*;

    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int NQ_W  = 2 * CNT_W;
    localparam int B     = SAMPLE_BITS;

    logic [AW-1:0]         r_pos;
    logic [CNT_W-1:0]      r_fill;
    logic [SUM_BITS-1:0]   r_sum;
    logic [SQ_BITS-1:0]    r_sumsq;

    logic [B-1:0]          r_x, r_old, ram_rdata;
    logic [2*B-1:0]        r_xsq, r_osq;
    logic [D_W-1:0]        r_s1sq, r_acc;
    logic [NQ_W-1:0]       r_nq, r_dvs, r_rem;
    logic [CNT_W-1:0]      r_mcnt;
    logic                  r_neg;
    logic [DQ_W-1:0]       r_dq;
    logic [D_W-1:0]        r_sx, r_res, r_bit;
    logic [MEAN_W-1:0]     r_mean_res;
    logic [STD_W-1:0]      r_std_res;

    logic [CNT_W-1:0]      len, fill_c, pos_inc;
    logic [AW-1:0]         pos_adj, pos_next;
    logic                  full;
    logic [B-1:0]          x_abs, old_abs;
    logic [SUM_BITS-1:0]   abs_sum;
    logic [2*SUM_BITS-1:0] s1_prod;
    logic [NQ_W-1:0]       nq_prod;
    logic [NQ_W:0]         div_t, div_diff;
    logic                  div_ge;
    logic [D_W-1:0]        sq_rb;
    logic [MEAN_W-1:0]     quot;

    wmsd_ram #(.WIDTH(B), .DEPTH(MAX_WINDOW)) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.square),
        .i_waddr (pos_adj),
        .i_wdata (r_x),
        .i_raddr (pos_adj),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (i_window_length == '0) begin
            len = CNT_W'(1);
        end else if (32'(i_window_length) > MAX_WINDOW) begin
            len = CNT_W'(MAX_WINDOW);
        end else begin
            len = CNT_W'(i_window_length);
        end
    end

    // wrap position and trim fill level after a length change
    assign pos_adj  = (CNT_W'(r_pos) >= len) ? '0 : r_pos;
    assign fill_c   = (r_fill > len) ? len : r_fill;
    assign full     = (fill_c == len);
    assign pos_inc  = CNT_W'(pos_adj) + CNT_W'(1);
    assign pos_next = (pos_inc >= len) ? '0 : AW'(pos_inc);

    assign x_abs   = r_x[B-1] ? (~r_x + 1'b1) : r_x;
    assign old_abs = ram_rdata[B-1] ? (~ram_rdata + 1'b1) : ram_rdata;
    assign abs_sum = r_sum[SUM_BITS-1] ? (~r_sum + 1'b1) : r_sum;
    assign s1_prod = abs_sum * abs_sum;
    assign nq_prod = r_fill * (r_fill - CNT_W'(1));

    assign div_t    = {r_rem, r_dq[DQ_W-1]};
    assign div_diff = div_t - {1'b0, r_dvs};
    assign div_ge   = (div_t >= {1'b0, r_dvs});

    assign sq_rb = r_res + r_bit;
    assign quot  = r_dq[MEAN_W-1:0];

    assign o_sts.var_ok = (r_fill >= CNT_W'(2)) && (r_acc >= r_s1sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_fill  <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
        end else if (i_cmd.clear) begin
            r_pos   <= '0;
            r_fill  <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
        end else if (i_cmd.update) begin
            r_pos   <= pos_next;
            r_fill  <= full ? fill_c : fill_c + CNT_W'(1);
            r_sum   <= r_sum - (full ? SUM_BITS'($signed(r_old)) : '0)
                       + SUM_BITS'($signed(r_x));
            r_sumsq <= r_sumsq - (full ? SQ_BITS'(r_osq) : '0) + SQ_BITS'(r_xsq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mean_res <= '0;
            r_std_res  <= '0;
        end
        if (i_cmd.rd) begin
            r_x <= i_sample;
        end
        if (i_cmd.square) begin
            r_old <= ram_rdata;
            r_xsq <= x_abs * x_abs;
            r_osq <= old_abs * old_abs;
        end
        if (i_cmd.prep) begin
            r_s1sq <= D_W'(s1_prod);
            r_nq   <= nq_prod;
            r_mcnt <= r_fill;
            r_acc  <= '0;
            r_neg  <= r_sum[SUM_BITS-1];
            r_dvs  <= NQ_W'(r_fill);
            r_rem  <= '0;
            r_dq   <= {abs_sum, 8'b0, {(DQ_W - NUM_W){1'b0}}};
        end
        if (i_cmd.mul_step) begin
            r_acc  <= (r_acc << 1) + (r_mcnt[CNT_W-1] ? D_W'(r_sumsq) : '0);
            r_mcnt <= r_mcnt << 1;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? div_diff[NQ_W-1:0] : div_t[NQ_W-1:0];
            r_dq  <= {r_dq[DQ_W-2:0], div_ge};
        end
        if (i_cmd.mean_cap) begin
            // floor towards minus infinity for a negative sum
            r_mean_res <= r_neg ? ((MEAN_W'(0) - quot) - MEAN_W'(|r_rem)) : quot;
        end
        if (i_cmd.divv_ld) begin
            r_dvs <= r_nq;
            r_rem <= '0;
            r_dq  <= {r_acc - r_s1sq, {FRAC_SHIFT{1'b0}}};
        end
        if (i_cmd.std_zero) begin
            r_std_res <= '0;
        end
        if (i_cmd.sqrt_ld) begin
            r_sx  <= r_dq[D_W-1:0];
            r_res <= '0;
            r_bit <= D_W'(1) << (D_W - 2);
        end
        if (i_cmd.sqrt_step) begin
            if (r_sx >= sq_rb) begin
                r_sx  <= r_sx - sq_rb;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.std_cap) begin
            r_std_res <= r_res[STD_W-1:0];
        end
        if (i_cmd.out_ld) begin
            o_mean  <= r_mean_res;
            o_std   <= r_std_res;
            o_count <= COUNT_W'(r_fill);
        end
    end
endmodule
`default_nettype wire

>>> bench/windowed_mean_and_std_dev_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_mean_and_std_dev_top_tb
// Drives add and clear words into the sliding-window statistics block, sets
// the window length over the APB port, and scores every result word against
// a bit-exact software predictor of mean, sample deviation and fill count.
// ----------------------------------------------------------------------------
module windowed_mean_and_std_dev_top_tb;
    import wmsd_pkg::*;

    typedef struct {
        logic [31:0] mean;
        logic [31:0] std_dev;
        logic [6:0]  count;
    } t_stats;

    class wmsd_scoreboard;
        longint              ring [64];
        int unsigned         wr_pos;
        int unsigned         fill;
        int unsigned         win_len;
        logic [SUM_BITS-1:0] sum;
        logic [SQ_BITS-1:0]  sq_sum;
        t_stats              pending [$];
        int                  errors;
        int                  accepted;

        function new();
            foreach (ring[i]) ring[i] = 0;
            wr_pos = 0; fill = 0; win_len = 64;
            sum = '0; sq_sum = '0; errors = 0; accepted = 0;
        endfunction

        function void set_length(logic [6:0] v);
            win_len = v;
        endfunction

        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= res + b) begin
                    x = x - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function void note_word(logic cmd, logic [23:0] smp);
            int unsigned     n;
            int unsigned     p;
            longint          x;
            longint          old;
            longint          s;
            longint          num;
            longint          q;
            longint          cnt_s;
            longint unsigned ax;
            longint unsigned aold;
            longint unsigned nq;
            longint unsigned s1sq;
            longint unsigned d;
            longint unsigned a;
            longint unsigned r;
            longint unsigned v;
            longint unsigned as;
            longint unsigned cnt_u;
            t_stats          e;
            accepted++;
            if (cmd == CMD_CLEAR) begin
                wr_pos = 0; fill = 0; sum = '0; sq_sum = '0;
                e.mean = '0; e.std_dev = '0; e.count = '0;
                pending.push_back(e);
                return;
            end
            n = (win_len == 0) ? 1 : (win_len > 64) ? 64 : win_len;
            x = $signed(smp);
            ax = (x < 0) ? -x : x;
            p = wr_pos;
            if (p >= n) p = 0;
            if (fill > n) fill = n;
            if (fill == n) begin
                old = ring[p];
                aold = (old < 0) ? -old : old;
                sum = sum - old[SUM_BITS-1:0];
                sq_sum = sq_sum - 54'(aold * aold);
            end else begin
                fill++;
            end
            ring[p] = x;
            sum = sum + x[SUM_BITS-1:0];
            sq_sum = sq_sum + 54'(ax * ax);
            p++;
            if (p >= n) p = 0;
            wr_pos = p;

            cnt_s = fill;
            cnt_u = fill;
            s = $signed(sum);
            num = s * 256;
            q = num / cnt_s;
            if ((num % cnt_s) != 0 && num < 0) q--;
            v = 0;
            if (fill >= 2) begin
                nq = cnt_u * (cnt_u - 1);
                as = (s < 0) ? -s : s;
                s1sq = as * as;
                d = cnt_u * {10'b0, sq_sum};
                if (d >= s1sq) begin
                    d = d - s1sq;
                    a = d / nq;
                    r = d % nq;
                    v = int_sqrt((a << 16) + ((r << 16) / nq));
                end
            end
            e.mean = q[31:0];
            e.std_dev = v[31:0];
            e.count = fill[6:0];
            pending.push_back(e);
        endfunction

        function void check_word(logic [71:0] w);
            t_stats e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, w);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (w[31:0] !== e.mean) begin
                $display("%0t: mean_q8 expected %h actual %h", $time, e.mean, w[31:0]);
                errors++;
            end
            if (w[63:32] !== e.std_dev) begin
                $display("%0t: std_dev_q8 expected %h actual %h", $time, e.std_dev,
                         w[63:32]);
                errors++;
            end
            if (w[70:64] !== e.count) begin
                $display("%0t: filled_count expected %0d actual %0d", $time, e.count,
                         w[70:64]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // sample
    logic        s_tuser  = 1'b0; // command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata; // mean_q8, std_dev_q8, filled_count
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    wmsd_scoreboard stats_sb = new();
    bit          quiet;
    bit          hold_done;
    int          hold_left;
    int          cycles;

    windowed_mean_and_std_dev_top uut (
        .i_clk, .i_rst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 4000000) begin
                $display("windowed_mean_and_std_dev_top verification failed");
                $finish;
            end
        end
    end

    // receiver: score words, stall at random, one long hold-off to back up the input
    initial begin
        hold_left = 0;
        hold_done = 0;
        forever begin
            int r;
            @(posedge i_clk);
            if (m_tvalid && m_tready) stats_sb.check_word(m_tdata);
            if (!hold_done && stats_sb.accepted >= 400) begin
                hold_done = 1;
                hold_left = 3000;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                r = $urandom_range(0, 999);
                if (!quiet) begin
                    if (r < 100) hold_left = $urandom_range(1, 3);
                    else if (r < 103) hold_left = $urandom_range(20, 200);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(30, 300);
    endfunction

    function automatic logic [23:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 24'h7FFFFF;
        if (r == 1) return 24'h800000;
        if (r < 5) return 24'($urandom_range(0, 2000) - 1000);
        return 24'($urandom);
    endfunction

    task automatic send_word(logic cmd, logic [23:0] smp, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= smp;
        do @(posedge i_clk); while (!s_tready);
        stats_sb.note_word(cmd, smp);
    endtask

    // drop valid and wait for every pending result, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (stats_sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_length(logic [6:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_WINDOW_LENGTH, 2'b00};
        pwdata  <= {25'b0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        stats_sb.set_length(v);
        @(posedge i_clk);
    endtask

    task automatic new_window(logic [6:0] v);
        write_length(v);
        send_word(CMD_CLEAR, 24'($urandom), 0);
    endtask

    initial begin
        int m;
        int c;
        logic [6:0] wl;
        quiet = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: default length, single sample, extremes, then odd lengths
        send_word(CMD_CLEAR, 24'h0, 0);
        send_word(CMD_ADD, 24'h7FFFFF, 0);
        send_word(CMD_ADD, 24'h800000, 1);
        send_word(CMD_ADD, 24'h000000, 0);
        send_word(CMD_ADD, 24'hFFFFFF, 0);
        send_word(CMD_ADD, 24'h000001, 2);
        send_word(CMD_CLEAR, 24'hFFFFFF, 0);
        send_word(CMD_ADD, 24'h800000, 0);
        drain();
        new_window(7'd1);
        send_word(CMD_ADD, 24'h123456, 0);
        send_word(CMD_ADD, 24'h800000, 0);
        drain();
        new_window(7'd0);
        send_word(CMD_ADD, 24'h7FFFFF, 0);
        send_word(CMD_ADD, 24'hABCDEF, 0);
        drain();
        new_window(7'd127);
        send_word(CMD_ADD, 24'h7FFFFF, 0);
        send_word(CMD_ADD, 24'h7FFFFF, 0);
        drain();
        new_window(7'd3);
        for (int i = 0; i < 5; i++) send_word(CMD_ADD, pick_sample(), 0);
        drain();

        // random phases: fresh length, clear, then mostly adds
        while (stats_sb.accepted < 1400) begin
            c = $urandom_range(0, 6);
            case (c)
                0: wl = 7'd1;
                1: wl = 7'd64;
                2: wl = 7'd0;
                3: wl = 7'($urandom_range(65, 127));
                4: wl = 7'($urandom_range(2, 16));
                default: wl = 7'($urandom_range(1, 64));
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            new_window(wl);
            m = $urandom_range(20, 150);
            for (int i = 0; i < m; i++) begin
                send_word(($urandom_range(0, 39) == 0) ? CMD_CLEAR : CMD_ADD,
                          pick_sample(), pick_gap());
            end
            drain();
        end

        quiet = 0;
        if (stats_sb.errors == 0) begin
            $display("windowed_mean_and_std_dev_top verification clean");
        end else begin
            $display("windowed_mean_and_std_dev_top verification failed");
        end
        $finish;
    end

endmodule
